@@ rtl/pgc_pkg.sv @@
// ----------------------------------------------------------------------------
// pgc_pkg - shared types and constants of the pointwise grouped convolution
// fixed field widths, table depths, op codes and lane payload types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgc_pkg;

  // fixed port geometry
  localparam int MaxIn       = 4;
  localparam int MaxOut      = 8;
  localparam int WeightDepth = 32;
  localparam int BiasDepth   = 8;
  localparam int BiasIdxW    = $clog2(BiasDepth);
  localparam int CoefIdxW    = 5;

  // fixed point widths: Q8.8 samples, Q4.12 weights, Q12.20 bias and result
  localparam int SampleW = 16;
  localparam int WeightW = 16;
  localparam int BiasW   = 32;
  localparam int ProdW   = SampleW + WeightW;
  localparam int AccW    = 35;
  localparam int OutW    = 32;

  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_BIAS   = 2'd2
  } op_e;

  typedef logic [MaxIn-1:0][SampleW-1:0]       pix_vec_t;
  typedef logic [WeightDepth-1:0][WeightW-1:0] weight_tab_t;
  typedef logic [BiasDepth-1:0][BiasW-1:0]     bias_tab_t;
  typedef logic [MaxOut-1:0][AccW-1:0]         acc_vec_t;
  typedef logic [MaxOut-1:0][OutW-1:0]         out_vec_t;

  // stage load enables shared by all lanes
  typedef struct packed {
    logic load_s1;
    logic load_s2;
  } pipe_ctrl_t;

endpackage

@@ rtl/pgc_lane.sv @@
// ----------------------------------------------------------------------------
// pgc_lane - one output channel of the pointwise convolution
// registered products of the group's samples and weights, then bias + sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgc_lane #(
  parameter int LANE         = 0,
  parameter int IN_CHANNELS  = 4,
  parameter int OUT_CHANNELS = 8,
  parameter int GROUPS       = 1
) (
  input  logic                             clk_i,
  input  pgc_pkg::pipe_ctrl_t              ctrl_i,
  input  pgc_pkg::pix_vec_t                pix_i,
  input  pgc_pkg::weight_tab_t             weights_i,
  input  logic [pgc_pkg::BiasW-1:0]        bias_i,
  output logic [pgc_pkg::AccW-1:0]         acc_o
);

  localparam int GW      = IN_CHANNELS / GROUPS;
  localparam int OPG     = OUT_CHANNELS / GROUPS;
  localparam int GRP_RAW = (OPG > 0) ? (LANE / OPG) : LANE;
  localparam int GRP     = (GRP_RAW > GROUPS - 1) ? (GROUPS - 1) : GRP_RAW;

  logic signed [pgc_pkg::ProdW-1:0] prod_w [pgc_pkg::MaxIn];
  logic signed [pgc_pkg::BiasW-1:0] bias_s1_q;
  logic signed [pgc_pkg::AccW-1:0]  acc_d;
  logic signed [pgc_pkg::AccW-1:0]  acc_q;

  // one multiplier per tap that belongs to this channel's group
  for (genvar i = 0; i < pgc_pkg::MaxIn; i++) begin : g_tap
    localparam int Ch   = GRP * GW + i;
    localparam int Widx = LANE * GW + i;
    if (i < GW && Ch < IN_CHANNELS && Widx < pgc_pkg::WeightDepth) begin : g_on
      logic signed [pgc_pkg::ProdW-1:0] prod_q;
      always_ff @(posedge clk_i) begin
        if (ctrl_i.load_s1) begin
          prod_q <= $signed(pix_i[Ch]) * $signed(weights_i[Widx]);
        end
      end
      assign prod_w[i] = prod_q;
    end else begin : g_off
      assign prod_w[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_s1) begin
      bias_s1_q <= $signed(bias_i);
    end
  end

  always_comb begin
    acc_d = pgc_pkg::AccW'(bias_s1_q);
    for (int i = 0; i < pgc_pkg::MaxIn; i++) begin
      acc_d = acc_d + pgc_pkg::AccW'(prod_w[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_s2) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/pgc_merge.sv @@
// ----------------------------------------------------------------------------
// pgc_merge - result stage of the pointwise convolution
// saturates every lane sum to 32 bits, output register plus skid register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgc_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  pgc_pkg::acc_vec_t   acc_i,
  output logic                valid_o,
  input  logic                ready_i,
  output pgc_pkg::out_vec_t   data_o
);

  localparam int OutW = pgc_pkg::OutW;
  localparam int AccW = pgc_pkg::AccW;

  pgc_pkg::out_vec_t sat_w;
  pgc_pkg::out_vec_t out_dat_d, out_dat_q;
  pgc_pkg::out_vec_t skid_dat_d, skid_dat_q;
  logic              out_vld_d, out_vld_q;
  logic              skid_vld_d, skid_vld_q;
  logic              take;

  // clamp each lane to the signed 32-bit range
  always_comb begin
    for (int k = 0; k < pgc_pkg::MaxOut; k++) begin
      if (acc_i[k][AccW-1:OutW-1] == '0 || acc_i[k][AccW-1:OutW-1] == '1) begin
        sat_w[k] = acc_i[k][OutW-1:0];
      end else if (acc_i[k][AccW-1]) begin
        sat_w[k] = {1'b1, {(OutW-1){1'b0}}};
      end else begin
        sat_w[k] = {1'b0, {(OutW-1){1'b1}}};
      end
    end
  end

  assign ready_o = !skid_vld_q;
  assign take    = valid_i && !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_dat_d  = out_dat_q;
    skid_vld_d = skid_vld_q;
    skid_dat_d = skid_dat_q;
    if (!out_vld_q || ready_i) begin
      out_vld_d  = skid_vld_q || take;
      out_dat_d  = skid_vld_q ? skid_dat_q : sat_w;
      skid_vld_d = 1'b0;
    end else if (take) begin
      skid_vld_d = 1'b1;
      skid_dat_d = sat_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dat_q  <= out_dat_d;
    skid_dat_q <= skid_dat_d;
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_dat_q;

endmodule

@@ rtl/pointwise_grouped_conv_bias_top.sv @@
// ----------------------------------------------------------------------------
// pointwise_grouped_conv_bias_top - 1x1 grouped convolution with bias
// weight/bias load items and pixel items in, one vector of outputs per pixel
// ----------------------------------------------------------------------------
// Usage: load items (op 1 weight, op 2 bias) write one coefficient each and
// give no result; a bias load to an index of 8 or more and op 3 are dropped.
// Every coefficient a pixel uses must be loaded before that pixel is sent.
// A pixel item (op 0) yields one result item with all output channels in
// Q12.20, saturated to 32 bits; channels at or above OUT_CHANNELS read zero.
// Throughput is one item per clock while in_ready_o is high, loads and
// pixels mixed freely. An accepted pixel passes the per-lane product
// registers, then the registered bias-plus-products sum, then the saturated
// output register (or the skid register while the output is stalled) in the
// merge stage. A coefficient loaded in one cycle is seen by a pixel accepted
// in the next. The output side has a skid register, so in_ready_o never
// depends combinationally on out_ready_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pointwise_grouped_conv_bias_top #(
  parameter int IN_CHANNELS  = 4,
  parameter int OUT_CHANNELS = 8,
  parameter int GROUPS       = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input item channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] pix_ch0_i,
  input  logic signed [15:0] pix_ch1_i,
  input  logic signed [15:0] pix_ch2_i,
  input  logic signed [15:0] pix_ch3_i,
  input  logic [4:0]         coef_index_i,
  input  logic signed [15:0] weight_value_i,
  input  logic signed [31:0] bias_value_i,
  // result item channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_ch0_o,
  output logic signed [31:0] out_ch1_o,
  output logic signed [31:0] out_ch2_o,
  output logic signed [31:0] out_ch3_o,
  output logic signed [31:0] out_ch4_o,
  output logic signed [31:0] out_ch5_o,
  output logic signed [31:0] out_ch6_o,
  output logic signed [31:0] out_ch7_o
);

  // coefficient tables, plain registers: each used entry feeds a fixed lane tap
  pgc_pkg::weight_tab_t weight_q;
  pgc_pkg::bias_tab_t   bias_q;

  pgc_pkg::pix_vec_t    pix_w;
  pgc_pkg::acc_vec_t    acc_w;
  pgc_pkg::out_vec_t    res_w;
  pgc_pkg::pipe_ctrl_t  ctrl;

  logic v1_d, v1_q;     // products stage holds a pixel
  logic v2_d, v2_q;     // sum stage holds a pixel
  logic en1, en2;
  logic merge_ready;
  logic in_acc;
  logic pix_acc;
  logic weight_we;
  logic bias_we;

  // stall chain ends at the merge stage's registered ready
  assign en2        = !v2_q || merge_ready;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign in_acc     = in_valid_i && en1;

  // decode the op of an accepted item
  always_comb begin
    pix_acc   = 1'b0;
    weight_we = 1'b0;
    bias_we   = 1'b0;
    case (pgc_pkg::op_e'(op_i))
      pgc_pkg::OP_PIXEL:  pix_acc   = in_acc;
      pgc_pkg::OP_WEIGHT: weight_we = in_acc;
      pgc_pkg::OP_BIAS:   bias_we   = in_acc && (coef_index_i[4:pgc_pkg::BiasIdxW] == '0);
      default: ;  // unused op: dropped
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (weight_we) begin
      weight_q[coef_index_i] <= weight_value_i;
    end
    if (bias_we) begin
      bias_q[coef_index_i[pgc_pkg::BiasIdxW-1:0]] <= bias_value_i;
    end
  end

  // pipeline occupancy
  assign v1_d = en1 ? pix_acc : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  assign ctrl.load_s1 = pix_acc;
  assign ctrl.load_s2 = en2 && v1_q;

  assign pix_w[0] = pix_ch0_i;
  assign pix_w[1] = pix_ch1_i;
  assign pix_w[2] = pix_ch2_i;
  assign pix_w[3] = pix_ch3_i;

  // one lane per output channel; unused channels give a zero sum
  for (genvar k = 0; k < pgc_pkg::MaxOut; k++) begin : g_lane
    if (k < OUT_CHANNELS) begin : g_on
      pgc_lane #(
        .LANE         (k),
        .IN_CHANNELS  (IN_CHANNELS),
        .OUT_CHANNELS (OUT_CHANNELS),
        .GROUPS       (GROUPS)
      ) u_lane (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .pix_i     (pix_w),
        .weights_i (weight_q),
        .bias_i    (bias_q[k]),
        .acc_o     (acc_w[k])
      );
    end else begin : g_off
      assign acc_w[k] = '0;
    end
  end

  // saturation, output register and skid
  pgc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .ready_o (merge_ready),
    .acc_i   (acc_w),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_w)
  );

  assign out_ch0_o = res_w[0];
  assign out_ch1_o = res_w[1];
  assign out_ch2_o = res_w[2];
  assign out_ch3_o = res_w[3];
  assign out_ch4_o = res_w[4];
  assign out_ch5_o = res_w[5];
  assign out_ch6_o = res_w[6];
  assign out_ch7_o = res_w[7];

endmodule

@@ rtl/pgc_checker.sv @@
// ----------------------------------------------------------------------------
// pgc_checker - port-level checks of the pointwise convolution
// result channel holding, input ready and unused channel behavior
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgc_checker #(
  parameter int OUT_CHANNELS = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_ch0_o,
  input logic signed [31:0] out_ch7_o
);

  // a result that is not taken stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_ch0_o) && $stable(out_ch7_o))
    else $error("stalled result item changed");

  // input only backs up when the pipeline is full, which shows a result
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // channel 7, beyond the configured count, reads zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (OUT_CHANNELS < 8) |-> out_ch7_o == 32'sd0)
    else $error("unused output channel not zero");

endmodule

bind pointwise_grouped_conv_bias_top pgc_checker #(
  .OUT_CHANNELS (OUT_CHANNELS)
) u_pgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_ch0_o   (out_ch0_o),
  .out_ch7_o   (out_ch7_o)
);
